@@ hdl/nfcp_pkg.sv @@
package nfcp_pkg;

    // Actions carried with each input request.
    localparam logic [1:0] ACT_WRITE_WAIT = 2'd0;
    localparam logic [1:0] ACT_ERASE_WAIT = 2'd1;
    localparam logic [1:0] ACT_READ       = 2'd2;

    // Status codes found by the write wait.
    localparam logic [2:0] ST_NOT_BUSY = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_SUSPEND  = 3'd3;
    localparam logic [2:0] ST_ABORT    = 3'd4;

    // Outcomes of a finished wait.
    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_ABORTED = 2'd1;
    localparam logic [1:0] OUT_FAILED  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PAIRED     = 2'd0;
    localparam logic [1:0] REG_BUS_WIDTH  = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT = 2'd2;

    // Bus width codes.
    localparam logic [1:0] BW_8  = 2'd0;
    localparam logic [1:0] BW_16 = 2'd1;

    // Status bits of a single flash lane.
    localparam logic [31:0] BIT_DQ1 = 32'h0000_0002;
    localparam logic [31:0] BIT_DQ2 = 32'h0000_0004;
    localparam logic [31:0] BIT_DQ5 = 32'h0000_0020;
    localparam logic [31:0] BIT_DQ6 = 32'h0000_0040;
    localparam logic [31:0] BIT_DQ7 = 32'h0000_0080;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] read_word;
        logic [31:0] expected_data;
        logic        buffer_write;
    } in_item_t;

    typedef struct packed {
        logic [31:0] actual_data;
        logic [2:0]  final_status;
        logic [1:0]  outcome;
    } out_item_t;

endpackage

@@ hdl/nor_flash_completion_poller_core.sv @@
// NOR flash completion poller.
//
// A request on the s_ channel either starts a write wait (action 0), starts
// an erase wait (action 1) or delivers one status word read from the flash
// (action 2). A write wait pairs reads to follow DQ6 toggling, confirms a
// buffer abort or a timeout with a further pair, checks erase suspend via
// DQ2 and finally compares one more read with the expected data. An erase
// wait completes on the first read that shows DQ7 set or a DQ5 failure.
// Each finished wait yields one result on the m_ channel.
// The user writes configuration registers through cfg_* only while no wait
// is running; the block itself does not enforce this. cfg_ready is always high.
// Throughput is one request per cycle while results are taken. A request is
// captured in the input register and evaluated once the result register can
// take a value; its result, if any, is registered there and shown on m_tvalid.
// When the receiver holds m_tready low with a result pending, the input
// register fills and s_tready falls until the result is taken.
// A synchronous reset (aresetn low) empties both registers, drops any wait
// and restores the configuration defaults (single device, 16-bit bus,
// poll limit 0xFFFFFFFF).
module nor_flash_completion_poller_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: read_word [31:0], expected_data [63:32], buffer_write [64], zero pad
    input  logic [nfcp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: action [1:0]
    input  logic [1:0]                          s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: outcome [1:0], final_status [4:2], actual_data [36:5], zero pad
    output logic [nfcp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);
    import nfcp_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_R1    = 4'd1;
    localparam logic [3:0] PH_R2    = 4'd2;
    localparam logic [3:0] PH_ABT3  = 4'd3;
    localparam logic [3:0] PH_ABT4  = 4'd4;
    localparam logic [3:0] PH_TMO3  = 4'd5;
    localparam logic [3:0] PH_TMO4  = 4'd6;
    localparam logic [3:0] PH_SUS3  = 4'd7;
    localparam logic [3:0] PH_SUS4  = 4'd8;
    localparam logic [3:0] PH_FINAL = 4'd9;
    localparam logic [3:0] PH_ERASE = 4'd10;

    // Configuration.
    logic        paired_reg;
    logic [1:0]  bus_width_reg;
    logic [31:0] poll_limit_reg;

    // Input register.
    logic        in_valid_reg;
    in_item_t    in_item_reg;

    // Wait state.
    logic [3:0]  phase_reg, phase_next;
    logic [31:0] first_read_reg, first_read_next;
    logic [31:0] polls_left_reg, polls_left_next;
    logic [31:0] expected_reg, expected_next;
    logic        buffer_mode_reg, buffer_mode_next;
    logic [2:0]  held_status_reg, held_status_next;

    // Result register.
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        fire;
    logic        res_valid;
    out_item_t   res_item;

    logic [31:0] mask_dq1, mask_dq2, mask_dq5, mask_dq6;
    logic [31:0] r_word, tog, dq2_diff;
    logic [31:0] erase_word, set7, set5, clr7;
    logic        erase_done, erase_fail;
    logic [2:0]  eval_status;
    logic        eval_end;

    assign cfg_ready = 1'b1;

    // The evaluation stage moves whenever the result register can take a value.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_item_reg};

    always_comb begin
        mask_dq1 = paired_reg ? (BIT_DQ1 | (BIT_DQ1 << 16)) : BIT_DQ1;
        mask_dq2 = paired_reg ? (BIT_DQ2 | (BIT_DQ2 << 16)) : BIT_DQ2;
        mask_dq5 = paired_reg ? (BIT_DQ5 | (BIT_DQ5 << 16)) : BIT_DQ5;
        mask_dq6 = paired_reg ? (BIT_DQ6 | (BIT_DQ6 << 16)) : BIT_DQ6;
    end

    // Erase checks at the configured bus width; the upper lane is added when paired, except on the 8-bit bus.
    always_comb begin
        set7 = BIT_DQ7;
        set5 = BIT_DQ5;
        clr7 = BIT_DQ7;
        erase_word = in_item_reg.read_word;
        case (bus_width_reg)
            BW_8: begin
                erase_word = {24'd0, in_item_reg.read_word[7:0]};
            end
            BW_16: begin
                erase_word = {16'd0, in_item_reg.read_word[15:0]};
                if (paired_reg) begin
                    set7 = BIT_DQ7 | (BIT_DQ7 << 8);
                    set5 = BIT_DQ5 | (BIT_DQ5 << 8);
                    clr7 = BIT_DQ7 | (BIT_DQ7 << 8);
                end
            end
            default: begin
                if (paired_reg) begin
                    set7 = BIT_DQ7 | (BIT_DQ7 << 16);
                    set5 = BIT_DQ5 | (BIT_DQ5 << 16);
                    clr7 = BIT_DQ7 | (BIT_DQ7 << 16);
                end
            end
        endcase
        erase_done = (erase_word & set7) == set7;
        erase_fail = ((erase_word & set5) == set5) && ((erase_word & clr7) == 32'd0);
    end

    always_comb begin
        r_word   = paired_reg ? in_item_reg.read_word
                              : {16'd0, in_item_reg.read_word[15:0]};
        tog      = (first_read_reg ^ r_word) & mask_dq6;
        dq2_diff = (first_read_reg ^ r_word) & mask_dq2;
    end

    always_comb begin
        phase_next       = phase_reg;
        first_read_next  = first_read_reg;
        polls_left_next  = polls_left_reg;
        expected_next    = expected_reg;
        buffer_mode_next = buffer_mode_reg;
        held_status_next = held_status_reg;
        res_valid        = 1'b0;
        res_item         = '0;
        eval_status      = ST_BUSY;
        eval_end         = 1'b0;

        if (in_item_reg.action == ACT_WRITE_WAIT) begin
            expected_next    = in_item_reg.expected_data;
            buffer_mode_next = in_item_reg.buffer_write;
            polls_left_next  = poll_limit_reg;
            held_status_next = ST_NOT_BUSY;
            phase_next       = PH_R1;
        end else if (in_item_reg.action == ACT_ERASE_WAIT) begin
            phase_next = PH_ERASE;
        end else if (in_item_reg.action == ACT_READ) begin
            case (phase_reg)
                PH_R1, PH_ABT3, PH_TMO3, PH_SUS3: begin
                    if (phase_reg == PH_R1) begin
                        polls_left_next = polls_left_reg - 32'd1;
                    end
                    first_read_next = r_word;
                    phase_next      = phase_reg + 4'd1;
                end
                PH_R2: begin
                    if (tog != 32'd0) begin
                        if (buffer_mode_reg && (((tog >> 5) & r_word) != 32'd0)) begin
                            phase_next = PH_ABT3;
                        end else if (((tog >> 1) & r_word) != 32'd0) begin
                            phase_next = PH_TMO3;
                        end else begin
                            eval_end    = 1'b1;
                            eval_status = ST_BUSY;
                        end
                    end else begin
                        phase_next = PH_SUS3;
                    end
                end
                PH_ABT4: begin
                    eval_end = 1'b1;
                    if ((((tog >> 5) & r_word) != 32'd0)
                            && ((tog >> 5) == (r_word & mask_dq1))) begin
                        eval_status = ST_ABORT;
                    end
                end
                PH_TMO4: begin
                    eval_end = 1'b1;
                    if ((((tog >> 1) & r_word) != 32'd0)
                            && ((tog >> 1) == (r_word & mask_dq5))) begin
                        eval_status = ST_TIMEOUT;
                    end
                end
                PH_SUS4: begin
                    eval_end = 1'b1;
                    if (dq2_diff == mask_dq2) begin
                        eval_status = ST_SUSPEND;
                    end else if (dq2_diff == 32'd0) begin
                        eval_status = ST_NOT_BUSY;
                    end
                end
                PH_FINAL: begin
                    res_valid = 1'b1;
                    if (held_status_reg == ST_NOT_BUSY) begin
                        res_item.outcome = (r_word == expected_reg) ? OUT_OK : OUT_FAILED;
                    end else if (held_status_reg == ST_ABORT) begin
                        res_item.outcome = OUT_ABORTED;
                    end else begin
                        res_item.outcome = OUT_FAILED;
                    end
                    res_item.final_status = held_status_reg;
                    res_item.actual_data  = r_word;
                    phase_next            = PH_IDLE;
                end
                PH_ERASE: begin
                    res_item.actual_data = erase_word;
                    if (erase_done) begin
                        res_valid             = 1'b1;
                        res_item.outcome      = OUT_OK;
                        res_item.final_status = ST_NOT_BUSY;
                        phase_next            = PH_IDLE;
                    end else if (erase_fail) begin
                        res_valid             = 1'b1;
                        res_item.outcome      = OUT_FAILED;
                        res_item.final_status = ST_TIMEOUT;
                        phase_next            = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase

            // A busy evaluation starts another while the poll budget lasts.
            if (eval_end) begin
                if (eval_status == ST_BUSY && polls_left_reg != 32'd0) begin
                    phase_next = PH_R1;
                end else begin
                    held_status_next = eval_status;
                    phase_next       = PH_FINAL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paired_reg     <= 1'b0;
            bus_width_reg  <= BW_16;
            poll_limit_reg <= 32'hFFFF_FFFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PAIRED:     paired_reg     <= cfg_data[0];
                REG_BUS_WIDTH:  bus_width_reg  <= cfg_data[1:0];
                REG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                default:        paired_reg     <= paired_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action        <= s_tuser;
            in_item_reg.read_word     <= s_tdata[31:0];
            in_item_reg.expected_data <= s_tdata[63:32];
            in_item_reg.buffer_write  <= s_tdata[64];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            first_read_reg  <= 32'd0;
            polls_left_reg  <= 32'd0;
            expected_reg    <= 32'd0;
            buffer_mode_reg <= 1'b0;
            held_status_reg <= ST_NOT_BUSY;
        end else if (fire) begin
            phase_reg       <= phase_next;
            first_read_reg  <= first_read_next;
            polls_left_reg  <= polls_left_next;
            expected_reg    <= expected_next;
            buffer_mode_reg <= buffer_mode_next;
            held_status_reg <= held_status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_item_reg <= res_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid |-> (phase_reg == PH_FINAL || phase_reg == PH_ERASE))
        else $error("result produced outside a completing phase");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid |=> phase_reg == PH_IDLE)
        else $error("wait not closed after its result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !fire)
        else $error("evaluation advanced while the result register is stalled");

    a_budget_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item_reg.action == ACT_WRITE_WAIT
        |=> polls_left_reg == $past(poll_limit_reg) && phase_reg == PH_R1)
        else $error("write wait did not load the poll budget");
`endif

endmodule
